// ----- sv/adll_pkg.sv -----
package adll_pkg;

    localparam int CELLS_DEF = 64;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_SEARCH = 3'd2;
    localparam logic [2:0] CMD_MIN    = 3'd3;
    localparam logic [2:0] CMD_MAX    = 3'd4;

    // -1 on the 7-bit index ports
    localparam logic [6:0] IDX_NONE = 7'h7F;

    localparam logic [31:0] KEY_SIGN = 32'h8000_0000;
    localparam logic [31:0] KEY_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic rd_en;
        logic key_we;
        logic lnk_we;
    } mem_ctl_t;

endpackage

// ----- sv/adll_store.sv -----
module adll_store #(
    parameter int CELLS = adll_pkg::CELLS_DEF
) (
    input  logic                               clk,
    input  adll_pkg::mem_ctl_t                 ctl,
    input  logic [$clog2(CELLS)-1:0]           rd_addr,
    input  logic [$clog2(CELLS)-1:0]           wr_addr,
    input  logic [31:0]                        key_wdata,
    input  logic [2*($clog2(CELLS)+1)-1:0]     lnk_wdata,
    output logic [31:0]                        key_rdata,
    output logic [2*($clog2(CELLS)+1)-1:0]     lnk_rdata
);
    import adll_pkg::*;

    localparam int IW = $clog2(CELLS);
    localparam int DW = 2 * (IW + 1);

    // link word: {prev, next}, each {valid, index}
    logic [31:0]   key_mem [CELLS];
    logic [DW-1:0] lnk_mem [CELLS];

    logic [31:0]   key_rd_reg;
    logic [DW-1:0] lnk_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.key_we)
        begin
            key_mem[wr_addr] <= key_wdata;
        end
        if (ctl.lnk_we)
        begin
            lnk_mem[wr_addr] <= lnk_wdata;
        end
        if (ctl.rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
            lnk_rd_reg <= lnk_mem[rd_addr];
        end
    end

    assign key_rdata = key_rd_reg;
    assign lnk_rdata = lnk_rd_reg;

endmodule

// ----- sv/array_doubly_linked_list.sv -----
// Doubly linked list held in a store of CELLS cells (key, prev link, next link)
// plus a head pointer kept in a register.
// Command channel: present cmd, cell_req, position and key_in with start high;
// the transfer happens on a rising edge where start is high and busy is low.
// Result channel: done is high for one cycle with index_out, key_out and found
// valid; the receiver cannot stall, so the result must be taken that cycle.
// Steps from the accepting edge to the done cycle:
//   rejected or unknown command, or walk of an empty list: done in the next cycle
//   insert: INS_P1, INS_P2, INS_P3 if a position is given, INS_N1, INS_N2, then
//   INS_N3 if a next cell exists; delete: DEL_1, DEL_2 if a previous cell exists,
//   DEL_3, then DEL_4 if a next cell exists; search, minimum, maximum: at most CELLS
//   cells, one per cycle through the single read port of the cell store, the next address taken from the read data.
// busy falls in the done cycle, so a new command can be taken there.
// Reset clears the head pointer (empty list) and the sequencer; the cell store
// is not cleared and needs no pass after reset.
module array_doubly_linked_list #(
    parameter int CELLS = adll_pkg::CELLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [6:0]  cell_req,
    input  logic [6:0]  position,
    input  logic [31:0] key_in,
    output logic        done,
    output logic [6:0]  index_out,
    output logic [31:0] key_out,
    output logic        found
);
    import adll_pkg::*;

    localparam int IW = $clog2(CELLS);
    localparam int LW = IW + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INS_P1 = 4'd1;
    localparam logic [3:0] S_INS_P2 = 4'd2;
    localparam logic [3:0] S_INS_P3 = 4'd3;
    localparam logic [3:0] S_INS_N1 = 4'd4;
    localparam logic [3:0] S_INS_N2 = 4'd5;
    localparam logic [3:0] S_INS_N3 = 4'd6;
    localparam logic [3:0] S_DEL_1  = 4'd7;
    localparam logic [3:0] S_DEL_2  = 4'd8;
    localparam logic [3:0] S_DEL_3  = 4'd9;
    localparam logic [3:0] S_DEL_4  = 4'd10;
    localparam logic [3:0] S_WALK   = 4'd11;

    localparam logic [LW-1:0] LNK_NONE = '0;
    localparam logic [IW-1:0] LAST_STEP = IW'(CELLS - 1);

    logic [3:0]    state_reg, state_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [IW-1:0] x_reg, x_next;
    logic [LW-1:0] p_reg, p_next;
    logic [LW-1:0] n_reg, n_next;
    logic [LW-1:0] head_reg, head_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] best_reg, best_next;
    logic [IW-1:0] steps_reg, steps_next;
    logic [31:0]   key_reg, key_next;
    logic [31:0]   bound_reg, bound_next;
    logic          done_reg, done_next;
    logic [6:0]    idx_out_reg, idx_out_next;
    logic [31:0]   key_out_reg, key_out_next;
    logic          found_reg, found_next;

    mem_ctl_t        ctl;
    logic [IW-1:0]   rd_addr, wr_addr;
    logic [31:0]     key_wdata, key_rdata;
    logic [2*LW-1:0] lnk_wdata, lnk_rdata;
    logic [LW-1:0]   rd_prev, rd_next;

    logic          c_ok, p_ok, pos_none;
    logic [IW-1:0] c_idx, p_idx;
    logic [31:0]   kx;
    logic          better, last;
    logic [31:0]   bound_upd;
    logic [IW-1:0] best_upd;

    adll_store #(
        .CELLS (CELLS)
    ) u_store (
        .clk       (clk),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .key_wdata (key_wdata),
        .lnk_wdata (lnk_wdata),
        .key_rdata (key_rdata),
        .lnk_rdata (lnk_rdata)
    );

    assign rd_prev = lnk_rdata[2*LW-1:LW];
    assign rd_next = lnk_rdata[LW-1:0];

    assign c_ok     = !cell_req[6] && ({26'd0, cell_req[5:0]} < 32'(CELLS));
    assign p_ok     = !position[6] && ({26'd0, position[5:0]} < 32'(CELLS));
    assign pos_none = (position == IDX_NONE);
    assign c_idx    = IW'(cell_req[5:0]);
    assign p_idx    = IW'(position[5:0]);

    // walk compare: sign flip turns signed order into unsigned order
    assign kx     = key_rdata ^ KEY_SIGN;
    assign better = (cmd_reg == CMD_MAX) ? (kx > bound_reg) : (kx < bound_reg);
    assign bound_upd = better ? kx : bound_reg;
    assign best_upd  = better ? cur_reg : best_reg;
    assign last      = !rd_next[IW] || (steps_reg == LAST_STEP);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        x_next       = x_reg;
        p_next       = p_reg;
        n_next       = n_reg;
        head_next    = head_reg;
        cur_next     = cur_reg;
        best_next    = best_reg;
        steps_next   = steps_reg;
        key_next     = key_reg;
        bound_next   = bound_reg;
        done_next    = 1'b0;
        idx_out_next = idx_out_reg;
        key_out_next = key_out_reg;
        found_next   = found_reg;

        ctl       = '0;
        rd_addr   = '0;
        wr_addr   = '0;
        key_wdata = key_reg;
        lnk_wdata = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    key_next = key_in;
                    x_next   = c_idx;
                    case (cmd)
                        CMD_INSERT:
                        begin
                            if (c_ok && p_ok)
                            begin
                                ctl.rd_en  = 1'b1;
                                rd_addr    = p_idx;
                                p_next     = {1'b1, p_idx};
                                state_next = S_INS_P1;
                            end
                            else if (c_ok && pos_none)
                            begin
                                // front insert: whole cell written at once
                                ctl.key_we = 1'b1;
                                ctl.lnk_we = 1'b1;
                                wr_addr    = c_idx;
                                key_wdata  = key_in;
                                lnk_wdata  = {LNK_NONE, head_reg};
                                head_next  = {1'b1, c_idx};
                                state_next = S_INS_N1;
                            end
                            else
                            begin
                                done_next    = 1'b1;
                                idx_out_next = cell_req;
                                key_out_next = '0;
                                found_next   = 1'b0;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (c_ok)
                            begin
                                ctl.rd_en  = 1'b1;
                                rd_addr    = c_idx;
                                state_next = S_DEL_1;
                            end
                            else
                            begin
                                done_next    = 1'b1;
                                idx_out_next = cell_req;
                                key_out_next = '0;
                                found_next   = 1'b0;
                            end
                        end
                        CMD_SEARCH, CMD_MIN, CMD_MAX:
                        begin
                            if (head_reg[IW])
                            begin
                                ctl.rd_en  = 1'b1;
                                rd_addr    = head_reg[IW-1:0];
                                cur_next   = head_reg[IW-1:0];
                                best_next  = head_reg[IW-1:0];
                                steps_next = '0;
                                bound_next = (cmd == CMD_MAX) ? '0 : KEY_ONES;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                done_next    = 1'b1;
                                idx_out_next = IDX_NONE;
                                key_out_next = '0;
                                found_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                            done_next    = 1'b1;
                            idx_out_next = IDX_NONE;
                            key_out_next = '0;
                            found_next   = 1'b0;
                        end
                    endcase
                end
            end
            S_INS_P1:
            begin
                ctl.key_we = 1'b1;
                ctl.lnk_we = 1'b1;
                wr_addr    = x_reg;
                lnk_wdata  = {p_reg, rd_next};
                state_next = S_INS_P2;
            end
            S_INS_P2:
            begin
                // re-read p: it may be the cell just written
                ctl.rd_en  = 1'b1;
                rd_addr    = p_reg[IW-1:0];
                state_next = S_INS_P3;
            end
            S_INS_P3:
            begin
                ctl.lnk_we = 1'b1;
                wr_addr    = p_reg[IW-1:0];
                lnk_wdata  = {rd_prev, 1'b1, x_reg};
                state_next = S_INS_N1;
            end
            S_INS_N1:
            begin
                ctl.rd_en  = 1'b1;
                rd_addr    = x_reg;
                state_next = S_INS_N2;
            end
            S_INS_N2:
            begin
                if (rd_next[IW])
                begin
                    ctl.rd_en  = 1'b1;
                    rd_addr    = rd_next[IW-1:0];
                    n_next     = rd_next;
                    state_next = S_INS_N3;
                end
                else
                begin
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    idx_out_next = 7'(x_reg);
                    key_out_next = key_reg;
                    found_next   = 1'b1;
                end
            end
            S_INS_N3:
            begin
                ctl.lnk_we   = 1'b1;
                wr_addr      = n_reg[IW-1:0];
                lnk_wdata    = {1'b1, x_reg, rd_next};
                state_next   = S_IDLE;
                done_next    = 1'b1;
                idx_out_next = 7'(x_reg);
                key_out_next = key_reg;
                found_next   = 1'b1;
            end
            S_DEL_1:
            begin
                key_next = key_rdata;
                p_next   = rd_prev;
                n_next   = rd_next;
                if (rd_prev[IW])
                begin
                    ctl.rd_en  = 1'b1;
                    rd_addr    = rd_prev[IW-1:0];
                    state_next = S_DEL_2;
                end
                else
                begin
                    head_next  = rd_next;
                    state_next = S_DEL_3;
                end
            end
            S_DEL_2:
            begin
                ctl.lnk_we = 1'b1;
                wr_addr    = p_reg[IW-1:0];
                lnk_wdata  = {rd_prev, n_reg};
                state_next = S_DEL_3;
            end
            S_DEL_3:
            begin
                if (n_reg[IW])
                begin
                    ctl.rd_en  = 1'b1;
                    rd_addr    = n_reg[IW-1:0];
                    state_next = S_DEL_4;
                end
                else
                begin
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    idx_out_next = 7'(x_reg);
                    key_out_next = key_reg;
                    found_next   = 1'b1;
                end
            end
            S_DEL_4:
            begin
                // p_reg is none when the deleted cell was the head
                ctl.lnk_we   = 1'b1;
                wr_addr      = n_reg[IW-1:0];
                lnk_wdata    = {p_reg, rd_next};
                state_next   = S_IDLE;
                done_next    = 1'b1;
                idx_out_next = 7'(x_reg);
                key_out_next = key_reg;
                found_next   = 1'b1;
            end
            S_WALK:
            begin
                if (cmd_reg == CMD_SEARCH && key_rdata == key_reg)
                begin
                    state_next   = S_IDLE;
                    done_next    = 1'b1;
                    idx_out_next = 7'(cur_reg);
                    key_out_next = key_rdata;
                    found_next   = 1'b1;
                end
                else if (last)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (cmd_reg == CMD_SEARCH)
                    begin
                        idx_out_next = IDX_NONE;
                        key_out_next = '0;
                        found_next   = 1'b0;
                    end
                    else
                    begin
                        idx_out_next = 7'(best_upd);
                        key_out_next = bound_upd ^ KEY_SIGN;
                        found_next   = 1'b1;
                    end
                end
                else
                begin
                    // next address straight from the read data
                    ctl.rd_en  = 1'b1;
                    rd_addr    = rd_next[IW-1:0];
                    cur_next   = rd_next[IW-1:0];
                    steps_next = steps_reg + 1'b1;
                    bound_next = bound_upd;
                    best_next  = best_upd;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= LNK_NONE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        x_reg       <= x_next;
        p_reg       <= p_next;
        n_reg       <= n_next;
        cur_reg     <= cur_next;
        best_reg    <= best_next;
        steps_reg   <= steps_next;
        key_reg     <= key_next;
        bound_reg   <= bound_next;
        idx_out_reg <= idx_out_next;
        key_out_reg <= key_out_next;
        found_reg   <= found_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign index_out = idx_out_reg;
    assign key_out   = key_out_reg;
    assign found     = found_reg;

endmodule

// ----- tb/sv/array_doubly_linked_list_tb.sv -----
`timescale 1ns / 100ps

module array_doubly_linked_list_tb;

    import adll_pkg::*;

    localparam int CELLS = CELLS_DEF;
    localparam int RANDOM_ITEMS = 700;

    localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;
    localparam logic [31:0] KEY_TOP         = 32'h7FFF_FFFF;

    typedef enum int {POOL_LIVE, POOL_FREE, POOL_STALE} pool_t;

    typedef struct packed {
        logic [6:0]  index;
        logic [31:0] key;
        logic        hit;
    } answer_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start;
    logic        busy;
    logic [2:0]  cmd;
    logic [6:0]  cell_req;
    logic [6:0]  position;
    logic [31:0] key_in;
    logic        done;
    logic [6:0]  index_out;
    logic [31:0] key_out;
    logic        found;

    class list_scoreboard;
        logic [31:0] key_of [CELLS];
        int          prev_of [CELLS];
        int          next_of [CELLS];
        int          head;
        bit          written [CELLS];
        bit          live [CELLS];
        int          live_count;
        int          longest;
        answer_t     answers_due [$];
        int          mismatches;
        int          checked;
        int          search_hits;
        int          rejected;
        int          op_seen [8];

        function new();
            for (int i = 0; i < CELLS; i++)
            begin
                key_of[i]  = '0;
                prev_of[i] = 0;
                next_of[i] = 0;
                written[i] = 1'b0;
                live[i]    = 1'b0;
            end
            head = -1;
            live_count = 0;
            longest = 0;
            mismatches = 0;
            checked = 0;
            search_hits = 0;
            rejected = 0;
            for (int i = 0; i < 8; i++)
                op_seen[i] = 0;
        endfunction

        function bit is_cell(int i);
            return i >= 0 && i < CELLS;
        endfunction

        // cells reachable from the head, capped as the hardware walk is
        function void refresh_live();
            int n;
            int steps;
            for (int i = 0; i < CELLS; i++)
                live[i] = 1'b0;
            live_count = 0;
            n = head;
            steps = 0;
            while (is_cell(n) && steps < CELLS)
            begin
                if (!live[n])
                    live_count++;
                live[n] = 1'b1;
                n = next_of[n];
                steps++;
            end
            if (live_count > longest)
                longest = live_count;
        endfunction

        function answer_t predict_answer(logic [2:0] op, logic [6:0] cell7,
                                         logic [6:0] pos7, logic [31:0] k);
            answer_t     a;
            int          x;
            int          p;
            int          n;
            int          r;
            int          steps;
            logic [31:0] bound;
            logic [31:0] ord;
            x = int'($signed(cell7));
            p = int'($signed(pos7));
            a.index = IDX_NONE;
            a.key = '0;
            a.hit = 1'b0;
            case (op)
                CMD_INSERT, CMD_DELETE:
                begin
                    a.index = cell7;
                    if (is_cell(x) && (op == CMD_DELETE || p == -1 || is_cell(p)))
                    begin
                        if (op == CMD_INSERT)
                        begin
                            key_of[x] = k;
                            written[x] = 1'b1;
                            if (is_cell(p))
                            begin
                                prev_of[x] = p;
                                next_of[x] = next_of[p];
                                next_of[p] = x;
                            end
                            else
                            begin
                                prev_of[x] = -1;
                                next_of[x] = head;
                                head = x;
                            end
                            n = next_of[x];
                            if (is_cell(n))
                                prev_of[n] = x;
                        end
                        else
                        begin
                            p = prev_of[x];
                            n = next_of[x];
                            if (is_cell(p))
                            begin
                                next_of[p] = n;
                                if (is_cell(n))
                                    prev_of[n] = p;
                            end
                            else
                            begin
                                head = n;
                                if (is_cell(n))
                                    prev_of[n] = -1;
                            end
                        end
                        a.key = key_of[x];
                        a.hit = 1'b1;
                    end
                end
                CMD_SEARCH, CMD_MIN, CMD_MAX:
                begin
                    n = head;
                    steps = 0;
                    if (op == CMD_SEARCH)
                    begin
                        r = -1;
                        while (is_cell(n) && steps < CELLS && r < 0)
                        begin
                            if (key_of[n] == k)
                                r = n;
                            n = next_of[n];
                            steps++;
                        end
                    end
                    else
                    begin
                        // sign bit flipped so that signed order is unsigned order
                        r = is_cell(head) ? head : -1;
                        bound = (op == CMD_MAX) ? '0 : KEY_ONES;
                        while (is_cell(n) && steps < CELLS)
                        begin
                            ord = key_of[n] ^ KEY_SIGN;
                            if ((op == CMD_MAX) ? (ord > bound) : (ord < bound))
                            begin
                                bound = ord;
                                r = n;
                            end
                            n = next_of[n];
                            steps++;
                        end
                    end
                    if (is_cell(r))
                    begin
                        a.index = 7'(r);
                        a.key = key_of[r];
                        a.hit = 1'b1;
                    end
                end
                default:
                    ;
            endcase
            return a;
        endfunction

        function void note_command(logic [2:0] op, logic [6:0] cell7,
                                   logic [6:0] pos7, logic [31:0] k);
            answer_t a;
            a = predict_answer(op, cell7, pos7, k);
            answers_due.push_back(a);
            op_seen[op]++;
            if (op == CMD_SEARCH && a.hit)
                search_hits++;
            if (op > CMD_MAX || ((op == CMD_INSERT || op == CMD_DELETE) && !a.hit))
                rejected++;
            refresh_live();
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, what);
        endfunction

        function void check_result(logic [6:0] idx, logic [31:0] k, logic hit);
            answer_t want;
            if (answers_due.size() == 0)
            begin
                report($sformatf("unexpected result: index %0d key %h found %b",
                                 $signed(idx), k, hit));
            end
            else
            begin
                want = answers_due.pop_front();
                checked++;
                if (idx !== want.index || k !== want.key || hit !== want.hit)
                    report($sformatf("expected index %0d key %h found %b, got %0d %h %b",
                                     $signed(want.index), want.key, want.hit,
                                     $signed(idx), k, hit));
            end
        endfunction
    endclass

    list_scoreboard sb;

    array_doubly_linked_list #(
        .CELLS(CELLS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .cell_req(cell_req),
        .position(position),
        .key_in(key_in),
        .done(done),
        .index_out(index_out),
        .key_out(key_out),
        .found(found)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result of an earlier command is checked before the one taken at this edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(index_out, key_out, found);
            if (start && !busy)
                sb.note_command(cmd, cell_req, position, key_in);
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic issue(input logic [2:0] op, input logic [6:0] c,
                         input logic [6:0] p, input logic [31:0] k);
        cmd      <= op;
        cell_req <= c;
        position <= p;
        key_in   <= k;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic sender_gap(input bit quiet);
        int r;
        int n;
        if (quiet)
            return;
        r = $urandom_range(0, 99);
        n = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (n == 0)
            return;
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (sb.answers_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [6:0] pick(pool_t pool);
        int cand [$];
        for (int i = 0; i < CELLS; i++)
            if ((pool == POOL_LIVE && sb.live[i]) || (pool == POOL_FREE && !sb.live[i]) ||
                (pool == POOL_STALE && sb.written[i] && !sb.live[i]))
                cand.push_back(i);
        if (cand.size() == 0)
            return IDX_NONE;
        return 7'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    // out of range, -1 included
    function automatic logic [6:0] bad_index();
        return 7'($urandom_range(64, 127));
    endfunction

    function automatic logic [6:0] pick_position();
        if ($urandom_range(0, 3) == 0)
            return IDX_NONE;
        return pick(POOL_LIVE);
    endfunction

    function automatic logic [31:0] draw_key();
        case ($urandom_range(0, 5))
            0: return KEY_SIGN;
            1: return KEY_TOP;
            2: return 32'($urandom_range(0, 7)) - 32'd3;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_command(input bit late);
        int          roll;
        int          ins_lim;
        logic [6:0]  c;
        logic [31:0] k;
        roll = $urandom_range(0, 99);
        k = draw_key();
        if (roll < (late ? 30 : 8))
        begin
            // malformed traffic; link corruption only late in the run
            case ($urandom_range(0, late ? 6 : 3))
                0: issue(CMD_INSERT, bad_index(), pick_position(), k);
                1: issue(CMD_INSERT, pick(POOL_FREE), 7'($urandom_range(64, 126)), k);
                2: issue(CMD_DELETE, bad_index(), pick_position(), k);
                3: issue(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
                         pick(POOL_LIVE), bad_index(), k);
                4: issue(CMD_INSERT, pick(POOL_LIVE), pick_position(), k);
                5: issue(CMD_DELETE, pick(POOL_STALE), bad_index(), k);
                default: issue(CMD_INSERT, pick(POOL_FREE), pick(POOL_STALE), k);
            endcase
        end
        else
        begin
            roll = $urandom_range(0, 99);
            ins_lim = (sb.live_count < 3) ? 85 : (sb.live_count > 48) ? 20 : 40;
            if (roll < ins_lim)
                issue(CMD_INSERT, pick(POOL_FREE), pick_position(), k);
            else if (roll < ins_lim + 25)
                issue(CMD_DELETE, pick(POOL_LIVE), bad_index(), k);
            else if (roll < ins_lim + 43)
            begin
                c = pick(POOL_LIVE);
                if (c != IDX_NONE && $urandom_range(0, 9) < 7)
                    k = sb.key_of[c[5:0]];
                issue(CMD_SEARCH, bad_index(), pick_position(), k);
            end
            else
                issue($urandom_range(0, 1) ? CMD_MIN : CMD_MAX, pick(POOL_LIVE),
                      pick_position(), k);
        end
    endtask

    initial
    begin
        int burst_left;
        sb = new();
        start    = 1'b0;
        cmd      = CMD_INSERT;
        cell_req = '0;
        position = IDX_NONE;
        key_in   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list, extremes of the key, ties, rejects, stale and cyclic links
        issue(CMD_MIN,    IDX_NONE, IDX_NONE, '0);
        issue(CMD_MAX,    IDX_NONE, IDX_NONE, '0);
        issue(CMD_SEARCH, IDX_NONE, IDX_NONE, '0);
        issue(CMD_INSERT, 7'd5,  IDX_NONE, KEY_TOP);
        issue(CMD_INSERT, 7'd0,  7'd5,     KEY_SIGN);
        issue(CMD_INSERT, 7'd63, IDX_NONE, 32'd0);
        issue(CMD_INSERT, 7'd10, 7'd0,     KEY_SIGN);
        issue(CMD_INSERT, 7'd20, 7'd5,     KEY_TOP);
        issue(CMD_MIN,    IDX_NONE, IDX_NONE, '0);
        issue(CMD_MAX,    IDX_NONE, IDX_NONE, '0);
        issue(CMD_SEARCH, IDX_NONE, IDX_NONE, KEY_TOP);
        issue(CMD_SEARCH, IDX_NONE, IDX_NONE, 32'd12345);
        issue(CMD_INSERT, IDX_NONE, IDX_NONE, 32'hFFFF_FFFF);
        issue(CMD_INSERT, 7'h40, 7'd5,  32'd1);
        issue(CMD_INSERT, 7'd30, 7'h40, 32'd1);
        issue(CMD_INSERT, 7'd30, 7'h7E, 32'd1);
        issue(CMD_DELETE, IDX_NONE, IDX_NONE, '0);
        issue(CMD_DELETE, 7'd63, IDX_NONE, '0);
        issue(CMD_DELETE, 7'd0,  IDX_NONE, '0);
        issue(CMD_DELETE, 7'd10, IDX_NONE, '0);
        issue(CMD_SPARE_FIRST, 7'd5, 7'd5, KEY_TOP);
        issue(CMD_SPARE_LAST,  7'h3F, 7'h40, 32'hA5A5_5A5A);
        issue(CMD_DELETE, 7'd0,  IDX_NONE, '0);
        issue(CMD_INSERT, 7'd5,  7'd5,     KEY_TOP);
        issue(CMD_SEARCH, IDX_NONE, IDX_NONE, 32'd777);
        issue(CMD_MIN,    IDX_NONE, IDX_NONE, '0);
        // cell 10 still ends in none, so this breaks the self loop
        issue(CMD_INSERT, 7'd5,  7'd10,    KEY_SIGN);

        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 175 == 174)
            begin
                start <= 1'b0;
                wait_drained();
            end
            random_command(n >= RANDOM_ITEMS * 85 / 100);
            if (burst_left > 0)
                burst_left--;
            else if ($urandom_range(0, 39) == 0)
                burst_left = 25;
            sender_gap(burst_left > 0);
        end
        start <= 1'b0;
        wait_drained();
        repeat (CELLS + 8) @(posedge clk);

        $display("covered %0d inserts, %0d deletes, %0d searches (%0d hits), %0d min, %0d max",
                 sb.op_seen[CMD_INSERT], sb.op_seen[CMD_DELETE], sb.op_seen[CMD_SEARCH],
                 sb.search_hits, sb.op_seen[CMD_MIN], sb.op_seen[CMD_MAX]);
        $display("%0d rejected or unknown commands, longest list %0d cells, %0d checked",
                 sb.rejected, sb.longest, sb.checked);
        if (sb.mismatches == 0 && sb.answers_due.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("%0d mismatches, %0d results never seen", sb.mismatches,
                     sb.answers_due.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", sb.answers_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
